>>> src/assert_macros.svh
// Assertion macros for the checker file of the semaphore unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define OCS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("semaphore unit assertion failed");

// Next-cycle implication, disabled while reset is high.
`define OCS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("semaphore unit assertion failed");

`endif

>>> src/ocs_pkg.sv
// Types, sizes and codes shared by the modules of the semaphore unit.
package ocs_pkg;

   localparam int NUM_SEMS    = 32;
   localparam int NUM_TASKS   = 16;
   localparam int QDEPTH      = (NUM_TASKS < 16) ? NUM_TASKS : 16;
   localparam int SLOT_W      = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
   localparam int Q_AW        = $clog2(QDEPTH);
   localparam int LEN_W       = $clog2(QDEPTH + 1);
   localparam int WAIT_AW     = SLOT_W + Q_AW;
   localparam int WAIT_DEPTH  = NUM_SEMS << Q_AW;
   localparam int TASK_W      = 4;
   localparam int INDEX_W     = 8;
   localparam int VALUE_W     = 16;
   localparam int COUNT_W     = 18;
   localparam int QUEUE_DEPTH = 2;
   localparam int QP_W        = $clog2(QUEUE_DEPTH);
   localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

   localparam logic [COUNT_W-1:0] COUNT_MAX = 18'h1FFFF;
   localparam logic [COUNT_W-1:0] COUNT_MIN = 18'h20000;

   typedef enum logic [1:0] {
      MODE_INIT    = 2'd0,
      MODE_WAIT    = 2'd1,
      MODE_SIGNAL  = 2'd2,
      MODE_DESTROY = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_RANGE     = 3'd1,
      ST_IN_USE    = 3'd2,
      ST_NOT_USED  = 3'd3,
      ST_NOT_OWNER = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_LOOK,
      BK_WAKE
   } back_state_type;

   typedef struct packed {
      mode_type            mode;
      logic                range_err;
      logic [SLOT_W-1:0]   slot;
      logic [VALUE_W-1:0]  init_value;
      logic [TASK_W-1:0]   caller;
   } ocs_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [TASK_W-1:0]  owner;
      logic [Q_AW-1:0]    head;
      logic [LEN_W-1:0]   len;
   } slot_word_type;

   localparam int SLOT_WORD_W = $bits(slot_word_type);

endpackage

>>> src/ocs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ocs_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> src/ocs_cmd_queue.sv
// Short command queue between the front and back parts of the semaphore unit.
module ocs_cmd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ocs_pkg::ocs_cmd_type push_data,
   input  logic                pop,
   output ocs_pkg::ocs_cmd_type pop_data,
   output ocs_pkg::q_stat_type stat
);
   import ocs_pkg::*;

   ocs_cmd_type      entry_ff [QUEUE_DEPTH];
   logic [QP_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QP_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QC_W-1:0]  fill_ff, fill_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data   = entry_ff[rd_ptr_ff];
   assign stat.full  = (fill_ff == QC_W'(QUEUE_DEPTH));
   assign stat.empty = (fill_ff == '0);

endmodule

>>> src/ocs_front.sv
// Front part: accepts request beats, checks the index and queues a command.
module ocs_front (
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_mode,
   input  logic [ocs_pkg::INDEX_W-1:0]   req_sem_index,
   input  logic [ocs_pkg::VALUE_W-1:0]   req_init_value,
   input  logic [ocs_pkg::TASK_W-1:0]    req_caller_task,
   input  ocs_pkg::q_stat_type           q_stat,
   output logic                          q_push,
   output ocs_pkg::ocs_cmd_type          q_cmd
);
   import ocs_pkg::*;

   assign req_stall = q_stat.full;
   assign q_push    = req_valid && !q_stat.full;

   always_comb begin
      q_cmd.mode       = mode_type'(req_mode);
      q_cmd.range_err  = ({1'b0, req_sem_index} >= (INDEX_W + 1)'(NUM_SEMS));
      q_cmd.slot       = req_sem_index[SLOT_W-1:0];
      q_cmd.init_value = req_init_value;
      q_cmd.caller     = req_caller_task;
   end

endmodule

>>> src/ocs_back.sv
// Back part: table read-modify-write, waiter queues and the result register.
module ocs_back (
   input  logic                         clock,
   input  logic                         reset,
   input  ocs_pkg::ocs_cmd_type         q_data,
   input  ocs_pkg::q_stat_type          q_stat,
   output logic                         q_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [2:0]                   rsp_status,
   output logic                         rsp_caller_blocked,
   output logic                         rsp_woken_valid,
   output logic [ocs_pkg::TASK_W-1:0]   rsp_woken_task,
   output logic                         rsp_last
);
   import ocs_pkg::*;

   function automatic logic [Q_AW-1:0] q_next(input logic [Q_AW-1:0] h);
      q_next = (h == Q_AW'(QDEPTH - 1)) ? '0 : h + 1'b1;
   endfunction

   function automatic logic [Q_AW-1:0] q_tail(input logic [Q_AW-1:0] h,
                                              input logic [LEN_W-1:0] n);
      logic [LEN_W:0] sum;
      sum = (LEN_W + 1)'(h) + (LEN_W + 1)'(n);
      if (sum >= (LEN_W + 1)'(QDEPTH)) begin
         sum = sum - (LEN_W + 1)'(QDEPTH);
      end
      q_tail = sum[Q_AW-1:0];
   endfunction

   back_state_type      state_ff, state_in;
   ocs_cmd_type         cmd_ff, cmd_in;
   logic [Q_AW-1:0]     head_ff, head_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [NUM_SEMS-1:0] in_use_ff, in_use_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [2:0]          rsp_status_ff, rsp_status_in;
   logic                rsp_blocked_ff, rsp_blocked_in;
   logic                rsp_wvalid_ff, rsp_wvalid_in;
   logic [TASK_W-1:0]   rsp_wtask_ff, rsp_wtask_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                   slot_rd_en;
   logic                   slot_we;
   slot_word_type          slot_wdata;
   logic [SLOT_WORD_W-1:0] slot_rdata;
   slot_word_type          cur;

   logic                wt_we;
   logic [WAIT_AW-1:0]  wt_waddr;
   logic                wt_re;
   logic [WAIT_AW-1:0]  wt_raddr;
   logic [TASK_W-1:0]   wt_rdata;

   logic                out_free;
   logic                cur_in_use;
   logic [COUNT_W-1:0]  cnt_dec;
   logic [COUNT_W-1:0]  cnt_inc;
   logic                wait_blocks;
   logic [Q_AW-1:0]     tail_pos;

   status_type          look_status;
   logic                look_emit;
   logic                look_blocked;
   logic                look_wake;
   logic                look_slot_we;
   logic                look_push;
   logic                look_set;
   logic                look_clr;
   slot_word_type       look_word;

   logic                emit;
   status_type          emit_status;
   logic                emit_blocked;
   logic                emit_wvalid;
   logic                emit_last;
   logic                load_work;
   logic                step_work;
   logic                set_use;
   logic                clr_use;

   assign cur      = slot_word_type'(slot_rdata);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cur_in_use  = in_use_ff[cmd_ff.slot];
      cnt_dec     = (cur.count == COUNT_MIN) ? cur.count : cur.count - 1'b1;
      cnt_inc     = (cur.count == COUNT_MAX) ? cur.count : cur.count + 1'b1;
      wait_blocks = cnt_dec[COUNT_W-1];
      tail_pos    = q_tail(cur.head, cur.len);

      look_status  = ST_OK;
      look_emit    = 1'b0;
      look_blocked = 1'b0;
      look_wake    = 1'b0;
      look_slot_we = 1'b0;
      look_push    = 1'b0;
      look_set     = 1'b0;
      look_clr     = 1'b0;
      look_word    = cur;

      priority if (cmd_ff.range_err) begin
         look_status = ST_RANGE;
         look_emit   = 1'b1;
      end else if (cmd_ff.mode == MODE_INIT) begin
         look_emit = 1'b1;
         if (cur_in_use) begin
            look_status = ST_IN_USE;
         end else begin
            look_slot_we    = 1'b1;
            look_set        = 1'b1;
            look_word.count = COUNT_W'(cmd_ff.init_value);
            look_word.owner = cmd_ff.caller;
            look_word.head  = '0;
            look_word.len   = '0;
         end
      end else if (!cur_in_use) begin
         look_status = ST_NOT_USED;
         look_emit   = 1'b1;
      end else begin
         unique case (cmd_ff.mode)
            MODE_WAIT: begin
               look_emit       = 1'b1;
               look_blocked    = wait_blocks;
               look_slot_we    = 1'b1;
               look_word.count = cnt_dec;
               if (wait_blocks && (cur.len < LEN_W'(QDEPTH))) begin
                  look_push     = 1'b1;
                  look_word.len = cur.len + 1'b1;
               end
            end
            MODE_SIGNAL: begin
               look_slot_we    = 1'b1;
               look_word.count = cnt_inc;
               if (cur.len == '0) begin
                  look_emit = 1'b1;
               end else begin
                  look_wake      = 1'b1;
                  look_word.head = q_next(cur.head);
                  look_word.len  = cur.len - 1'b1;
               end
            end
            MODE_DESTROY: begin
               if (cur.owner != cmd_ff.caller) begin
                  look_status = ST_NOT_OWNER;
                  look_emit   = 1'b1;
               end else if (cur.len == '0) begin
                  look_emit = 1'b1;
                  look_clr  = 1'b1;
               end else begin
                  look_wake = 1'b1;
               end
            end
            default: begin
               look_status = ST_OK;
            end
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_stat.empty) begin
               state_in = BK_LOOK;
            end
         end
         BK_LOOK: begin
            if (out_free) begin
               state_in = look_wake ? BK_WAKE : BK_IDLE;
            end
         end
         BK_WAKE: begin
            if (out_free && (len_ff == '0)) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      q_pop        = 1'b0;
      slot_rd_en   = 1'b0;
      slot_we      = 1'b0;
      wt_we        = 1'b0;
      wt_re        = 1'b0;
      wt_waddr     = {cmd_ff.slot, tail_pos};
      wt_raddr     = {cmd_ff.slot, cur.head};
      emit         = 1'b0;
      emit_status  = ST_OK;
      emit_blocked = 1'b0;
      emit_wvalid  = 1'b0;
      emit_last    = 1'b1;
      load_work    = 1'b0;
      step_work    = 1'b0;
      set_use      = 1'b0;
      clr_use      = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_stat.empty) begin
               q_pop      = 1'b1;
               slot_rd_en = 1'b1;
            end
         end
         BK_LOOK: begin
            if (out_free) begin
               emit         = look_emit;
               emit_status  = look_status;
               emit_blocked = look_blocked;
               slot_we      = look_slot_we;
               wt_we        = look_push;
               wt_re        = look_wake;
               load_work    = look_wake;
               set_use      = look_set;
               clr_use      = look_clr;
            end
         end
         BK_WAKE: begin
            wt_raddr = {cmd_ff.slot, head_ff};
            if (out_free) begin
               emit        = 1'b1;
               emit_wvalid = 1'b1;
               emit_last   = (len_ff == '0);
               if (len_ff != '0) begin
                  wt_re     = 1'b1;
                  step_work = 1'b1;
               end else if (cmd_ff.mode == MODE_DESTROY) begin
                  clr_use = 1'b1;
               end
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   always_comb begin
      slot_wdata = look_word;
      cmd_in     = q_pop ? q_data : cmd_ff;
      head_in    = head_ff;
      len_in     = len_ff;
      if (load_work) begin
         head_in = q_next(cur.head);
         len_in  = (cmd_ff.mode == MODE_SIGNAL) ? '0 : cur.len - 1'b1;
      end else if (step_work) begin
         head_in = q_next(head_ff);
         len_in  = len_ff - 1'b1;
      end
      in_use_in = in_use_ff;
      if (set_use) begin
         in_use_in[cmd_ff.slot] = 1'b1;
      end
      if (clr_use) begin
         in_use_in[cmd_ff.slot] = 1'b0;
      end
      rsp_valid_in   = emit ? 1'b1 : (rsp_valid_ff && rsp_stall);
      rsp_status_in  = emit ? emit_status : rsp_status_ff;
      rsp_blocked_in = emit ? emit_blocked : rsp_blocked_ff;
      rsp_wvalid_in  = emit ? emit_wvalid : rsp_wvalid_ff;
      rsp_wtask_in   = emit ? (emit_wvalid ? wt_rdata : '0) : rsp_wtask_ff;
      rsp_last_in    = emit ? emit_last : rsp_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         in_use_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_use_ff    <= in_use_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      head_ff        <= head_in;
      len_ff         <= len_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_blocked_ff <= rsp_blocked_in;
      rsp_wvalid_ff  <= rsp_wvalid_in;
      rsp_wtask_ff   <= rsp_wtask_in;
      rsp_last_ff    <= rsp_last_in;
   end

   ocs_ram #(
      .WIDTH  (SLOT_WORD_W),
      .DEPTH  (NUM_SEMS),
      .ADDR_W (SLOT_W)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (cmd_ff.slot),
      .wr_data (slot_wdata),
      .rd_en   (slot_rd_en),
      .rd_addr (q_data.slot),
      .rd_data (slot_rdata)
   );

   ocs_ram #(
      .WIDTH  (TASK_W),
      .DEPTH  (WAIT_DEPTH),
      .ADDR_W (WAIT_AW)
   ) u_waiter_ram (
      .clock   (clock),
      .wr_en   (wt_we),
      .wr_addr (wt_waddr),
      .wr_data (cmd_ff.caller),
      .rd_en   (wt_re),
      .rd_addr (wt_raddr),
      .rd_data (wt_rdata)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_caller_blocked = rsp_blocked_ff;
   assign rsp_woken_valid    = rsp_wvalid_ff;
   assign rsp_woken_task     = rsp_wtask_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

>>> src/owned_counting_semaphore_unit_core.sv
// Top level of the owned counting semaphore unit.
//
//   Channel   Direction  Handshake          Beat contents
//   req_      in         req_valid/stall    mode, index, init value, caller task
//   rsp_      out        rsp_valid/stall    status, blocked, woken task, last
//
// Init, wait, signal without waiters and every rejected request pass through the back
// part as a read of the slot table entry, then a step that updates it, if the request
// is accepted, and registers the result. Signal with a waiter adds a waiter memory read
// after the slot read; destroy adds one such read and one result per released waiter.
// Reset clears the in-use bits at once; the table contents need no clearing pass.
// A stalled result holds the back part; the two-entry command queue then fills
// and stalls the request side.
module owned_counting_semaphore_unit_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_mode,
   input  logic [ocs_pkg::INDEX_W-1:0]  req_sem_index,
   input  logic [ocs_pkg::VALUE_W-1:0]  req_init_value,
   input  logic [ocs_pkg::TASK_W-1:0]   req_caller_task,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [2:0]                   rsp_status,
   output logic                         rsp_caller_blocked,
   output logic                         rsp_woken_valid,
   output logic [ocs_pkg::TASK_W-1:0]   rsp_woken_task,
   output logic                         rsp_last
);
   import ocs_pkg::*;

   q_stat_type  q_stat;
   logic        q_push;
   logic        q_pop;
   ocs_cmd_type q_cmd;
   ocs_cmd_type q_data;

   ocs_front u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_sem_index   (req_sem_index),
      .req_init_value  (req_init_value),
      .req_caller_task (req_caller_task),
      .q_stat          (q_stat),
      .q_push          (q_push),
      .q_cmd           (q_cmd)
   );

   ocs_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_cmd),
      .pop       (q_pop),
      .pop_data  (q_data),
      .stat      (q_stat)
   );

   ocs_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_data             (q_data),
      .q_stat             (q_stat),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_caller_blocked (rsp_caller_blocked),
      .rsp_woken_valid    (rsp_woken_valid),
      .rsp_woken_task     (rsp_woken_task),
      .rsp_last           (rsp_last)
   );

endmodule

>>> src/ocs_checker.sv
// Port-level checker for the semaphore unit, bound to its top level.
`include "assert_macros.svh"

module ocs_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic [1:0]                   req_mode,
   input logic [ocs_pkg::INDEX_W-1:0]  req_sem_index,
   input logic [ocs_pkg::VALUE_W-1:0]  req_init_value,
   input logic [ocs_pkg::TASK_W-1:0]   req_caller_task,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [2:0]                   rsp_status,
   input logic                         rsp_caller_blocked,
   input logic                         rsp_woken_valid,
   input logic [ocs_pkg::TASK_W-1:0]   rsp_woken_task,
   input logic                         rsp_last
);
   import ocs_pkg::*;

   // A stalled result beat stays valid, with its status, woken task and last flag unchanged.
   `OCS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_woken_task) && $stable(rsp_last))

   // A rejected request gives a single, plain result.
   `OCS_ASSERT_IMP(a_err_plain, clock, reset, rsp_valid && (rsp_status != ST_OK), rsp_last && !rsp_woken_valid && !rsp_caller_blocked && (rsp_woken_task == '0))

   // A blocked caller is reported only on a successful wait, never with a woken task.
   `OCS_ASSERT_IMP(a_blocked_alone, clock, reset, rsp_valid && rsp_caller_blocked, (rsp_status == ST_OK) && rsp_last && !rsp_woken_valid)

   // Without a released waiter the task field reads zero.
   `OCS_ASSERT_IMP(a_task_zero, clock, reset, rsp_valid && !rsp_woken_valid, rsp_woken_task == '0)

   // Only defined status codes appear.
   `OCS_ASSERT_IMP(a_status_code, clock, reset, rsp_valid, (rsp_status == ST_OK) || (rsp_status == ST_RANGE) || (rsp_status == ST_IN_USE) || (rsp_status == ST_NOT_USED) || (rsp_status == ST_NOT_OWNER))

endmodule

bind owned_counting_semaphore_unit_core ocs_checker u_ocs_checker (.*);
